// ----- rtl/mssd_pkg.sv -----
// Package for the multiplexed seven-segment decimal driver: widths, codes, types and helpers.
package mssd_pkg;

	// Input value width and BCD width (five digits cover 0..65535)
	localparam int VAL_W      = 16;
	localparam int BCD_DIGITS = 5;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int WORD_W     = BCD_W + VAL_W;

	// Double-dabble shift steps done in each conversion stage
	localparam int STEPS_PER_STAGE = 4;

	// Display geometry
	localparam int SEL_W  = 4;
	localparam int SEG_W  = 7;
	localparam int TDATA_W = 16;

	// Active-low digit select codes
	localparam logic [SEL_W-1:0] SEL_UNITS     = 4'hE;
	localparam logic [SEL_W-1:0] SEL_TENS      = 4'hD;
	localparam logic [SEL_W-1:0] SEL_HUNDREDS  = 4'hB;
	localparam logic [SEL_W-1:0] SEL_THOUSANDS = 4'h7;

	// Segment pattern when nothing is lit
	localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;

	// Converted item waiting to be shown: one pattern per digit, units first
	typedef struct packed {
		logic [3:0][SEG_W-1:0] shapes;
		logic [1:0]            last_idx;
	} disp_t;

	// Segment shape of a decimal digit; blank for anything above nine
	function automatic logic [SEG_W-1:0] seg_shape(input logic [3:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 7'h3F;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5B;
			4'd3: s = 7'h4F;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6D;
			4'd6: s = 7'h7D;
			4'd7: s = 7'h07;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h6F;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

	// A few double-dabble steps: {bcd, binary} word, binary shifts out of the top
	function automatic logic [WORD_W-1:0] dd_steps(input logic [WORD_W-1:0] w_in);
		logic [WORD_W-1:0] w;
		logic [3:0]        nib;
		w = w_in;
		for (int s = 0; s < STEPS_PER_STAGE; s++) begin
			for (int n = 0; n < BCD_DIGITS; n++) begin
				nib = w[VAL_W + 4*n +: 4];
				if (nib >= 4'd5) begin
					w[VAL_W + 4*n +: 4] = nib + 4'd3;
				end
			end
			w = {w[WORD_W-2:0], 1'b0};
		end
		return w;
	endfunction

endpackage

// ----- rtl/multiplexed_seven_segment_decimal_top.sv -----
// Multiplexed seven-segment decimal driver: pipelined binary to BCD and frame serialiser.
//
// Each 16-bit value on the slave stream is converted to decimal and sent out as one frame per
// shown digit, units first, on the master stream; leading zeros are blanked, so a value gives
// one to four frames and the final one carries tlast. A thousands count above nine (values over
// 9999) gives a frame with all segments off. The conversion runs through four register stages of
// four shift-and-correct steps each, then a frame register. The frame register sends one frame
// per cycle while m_tready is high, and the next value follows straight after its last frame;
// up to four further values sit in the conversion stages meanwhile.
module multiplexed_seven_segment_decimal_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [mssd_pkg::VAL_W-1:0]   s_tdata,   // [15:0] value
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [mssd_pkg::TDATA_W-1:0] m_tdata,   // [3:0] digit_select_n, [10:4] segments, rest 0
	output logic                         m_tlast
);

	localparam int W = mssd_pkg::WORD_W;

	logic         vld_s1, vld_s2, vld_s3, vld_s4;
	logic [W-1:0] w_s1, w_s2, w_s3, w_s4;
	logic         rdy_in1, rdy_in2, rdy_in3, rdy_in4, rdy_in5;

	logic                   hold_vld_q;
	logic [1:0]             idx_q;
	mssd_pkg::disp_t        disp_q;
	mssd_pkg::disp_t        disp_load;
	logic [mssd_pkg::BCD_W-1:0] bcd;
	logic                   frame_last;

	// Ready chain: a stage takes an item when empty or when it empties this cycle
	assign frame_last = (idx_q == disp_q.last_idx);
	assign rdy_in5    = !hold_vld_q || (m_tready && frame_last);
	assign rdy_in4    = !vld_s4 || rdy_in5;
	assign rdy_in3    = !vld_s3 || rdy_in4;
	assign rdy_in2    = !vld_s2 || rdy_in3;
	assign rdy_in1    = !vld_s1 || rdy_in2;
	assign s_tready   = rdy_in1;

	// Conversion stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_in1) vld_s1 <= s_tvalid;
			if (rdy_in2) vld_s2 <= vld_s1;
			if (rdy_in3) vld_s3 <= vld_s2;
			if (rdy_in4) vld_s4 <= vld_s3;
		end
	end

	// Conversion stage payload: four double-dabble steps per stage
	always_ff @(posedge clk) begin
		if (rdy_in1 && s_tvalid) begin
			w_s1 <= mssd_pkg::dd_steps({{mssd_pkg::BCD_W{1'b0}}, s_tdata});
		end
		if (rdy_in2 && vld_s1) w_s2 <= mssd_pkg::dd_steps(w_s1);
		if (rdy_in3 && vld_s2) w_s3 <= mssd_pkg::dd_steps(w_s2);
		if (rdy_in4 && vld_s3) w_s4 <= mssd_pkg::dd_steps(w_s3);
	end

	// Shapes and frame count from the finished BCD digits
	assign bcd = w_s4[W-1 -: mssd_pkg::BCD_W];
	always_comb begin
		disp_load.shapes[0] = mssd_pkg::seg_shape(bcd[3:0]);
		disp_load.shapes[1] = mssd_pkg::seg_shape(bcd[7:4]);
		disp_load.shapes[2] = mssd_pkg::seg_shape(bcd[11:8]);
		// thousands count of ten or more has no shape
		disp_load.shapes[3] = (bcd[19:16] != 4'd0) ? mssd_pkg::SEG_BLANK
		                                             : mssd_pkg::seg_shape(bcd[15:12]);
		if (bcd[19:12] != 8'd0) begin
			disp_load.last_idx = 2'd3;
		end else if (bcd[11:8] != 4'd0) begin
			disp_load.last_idx = 2'd2;
		end else if (bcd[7:4] != 4'd0) begin
			disp_load.last_idx = 2'd1;
		end else begin
			disp_load.last_idx = 2'd0;
		end
	end

	// Frame register control: load a new item when empty or after the last frame goes, else step the digit on tready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q <= 1'b0;
			idx_q      <= 2'd0;
		end else if (rdy_in5) begin
			hold_vld_q <= vld_s4;
			idx_q      <= 2'd0;
		end else if (m_tready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// Frame register payload
	always_ff @(posedge clk) begin
		if (rdy_in5 && vld_s4) begin
			disp_q <= disp_load;
		end
	end

	// Frame fields
	assign m_tvalid = hold_vld_q;
	assign m_tlast  = frame_last;
	assign m_tdata  = {{(mssd_pkg::TDATA_W - mssd_pkg::SEG_W - mssd_pkg::SEL_W){1'b0}},
	                   disp_q.shapes[idx_q],
	                   ~(4'b0001 << idx_q)};

	// The thousands frame always closes its item
	a_thousands_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[3:0] == mssd_pkg::SEL_THOUSANDS) |-> m_tlast)
		else $error("thousands frame not marked last");

	// Frames of one item follow each other with no gap
	a_frames_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside an item's frames");

	// Blank segments only on the thousands frame
	a_blank_thousands: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[10:4] == mssd_pkg::SEG_BLANK)
		|-> (m_tdata[3:0] == mssd_pkg::SEL_THOUSANDS))
		else $error("blank segments on a lower digit");

	// Exactly one digit enabled
	a_select_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot(~m_tdata[3:0]))
		else $error("digit select not one-hot");

endmodule

// ----- sim/multiplexed_seven_segment_decimal_top_tb.sv -----
// Testbench for the multiplexed seven-segment decimal driver: directed table, random values, frame checks.
`timescale 1ns / 1ps

module multiplexed_seven_segment_decimal_top_tb;

	localparam int VAL_W   = mssd_pkg::VAL_W;
	localparam int SEG_W   = mssd_pkg::SEG_W;
	localparam int SEL_W   = mssd_pkg::SEL_W;
	localparam int TDATA_W = mssd_pkg::TDATA_W;

	localparam int DIR_N       = 20;
	localparam int RAND_N      = 140;
	localparam int HOLD_CYCLES = 100;
	localparam int IDLE_PCT    = 37;

	// One digit frame as seen on the master stream
	typedef struct packed {
		logic             last;
		logic [SEG_W-1:0] seg;
		logic [SEL_W-1:0] sel;
	} frame_t;

	// Directed row: value, and where typed in, the frames it must give
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [2:0]       n_typed;
		frame_t [3:0]     typed;
	} row_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [VAL_W-1:0]    s_tdata  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;
	logic                m_tlast;

	// Digit shapes, a in bit 0 through g in bit 6
	logic [SEG_W-1:0] shape_lut [10] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
	                                     7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};

	frame_t pending_frames [$];
	int     mismatches   = 0;
	bit     steady       = 1'b0;
	bit     hold_request = 1'b0;

	multiplexed_seven_segment_decimal_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Overall time limit
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic frame_t frame_of(input logic last, input logic [SEG_W-1:0] seg,
	                                    input logic [SEL_W-1:0] sel);
		frame_t f;
		f.last = last;
		f.seg  = seg;
		f.sel  = sel;
		return f;
	endfunction

	function automatic row_t row(input logic [VAL_W-1:0] value, input int n,
	                             input frame_t f0, input frame_t f1,
	                             input frame_t f2, input frame_t f3);
		row_t r;
		r.value   = value;
		r.n_typed = 3'(n);
		r.typed   = {f3, f2, f1, f0};
		return r;
	endfunction

	// Split a value into its shown digits, units first, and queue the frames
	function automatic void queue_digit_frames(input logic [VAL_W-1:0] v);
		int unsigned n;
		int unsigned shown;
		int unsigned digit [4];
		frame_t      f;
		n        = 32'(v);
		digit[0] = n % 10;
		digit[1] = (n / 10) % 10;
		digit[2] = (n / 100) % 10;
		digit[3] = n / 1000;
		shown = (n > 999) ? 4 : (n > 99) ? 3 : (n > 9) ? 2 : 1;
		for (int k = 0; k < shown; k++) begin
			f.sel  = ~(SEL_W'(1) << k);
			// thousands count of ten or more has no shape
			f.seg  = (digit[k] > 9) ? mssd_pkg::SEG_BLANK : shape_lut[digit[k]];
			f.last = (k == shown - 1);
			pending_frames.push_back(f);
		end
	endfunction

	task automatic report_mismatch(input string field, input int unsigned want,
	                               input int unsigned got);
		if (mismatches < 10)
			$display("mismatch on %s at %0t: expected 0x%0h, got 0x%0h",
			         field, $realtime, want, got);
		mismatches++;
	endtask

	// Offer one value, with random gaps before it, and return once it is taken
	task automatic offer_value(input logic [VAL_W-1:0] v);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			s_tdata  <= VAL_W'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Receiver: random stalls, a calm stretch, and one long hold-off on request
	initial begin : sink
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Frame checker
	always @(posedge clk) begin
		frame_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_frames.size() == 0) begin
				report_mismatch("unexpected frame", 0, 32'(m_tdata));
			end else begin
				want = pending_frames.pop_front();
				if (m_tdata[SEL_W-1:0] !== want.sel)
					report_mismatch("digit_select_n", 32'(want.sel),
					                32'(m_tdata[SEL_W-1:0]));
				if (m_tdata[SEL_W +: SEG_W] !== want.seg)
					report_mismatch("segments", 32'(want.seg),
					                32'(m_tdata[SEL_W +: SEG_W]));
				if (m_tdata[TDATA_W-1:SEL_W+SEG_W] !== '0)
					report_mismatch("tdata padding", 0,
					                32'(m_tdata[TDATA_W-1:SEL_W+SEG_W]));
				if (m_tlast !== want.last)
					report_mismatch("tlast", 32'(want.last), 32'(m_tlast));
			end
		end
	end

	// Stimulus
	initial begin : stimulus
		row_t             dir_tab [DIR_N];
		frame_t           nil;
		logic [VAL_W-1:0] v;
		int unsigned      edges [4];

		nil      = '0;
		edges    = '{10, 100, 1000, 10000};
		dir_tab  = '{
			row(16'd0, 1, frame_of(1'b1, 7'h3F, mssd_pkg::SEL_UNITS), nil, nil, nil),
			row(16'd9, 1, frame_of(1'b1, 7'h6F, mssd_pkg::SEL_UNITS), nil, nil, nil),
			row(16'd9999, 4, frame_of(1'b0, 7'h6F, mssd_pkg::SEL_UNITS),
			    frame_of(1'b0, 7'h6F, mssd_pkg::SEL_TENS),
			    frame_of(1'b0, 7'h6F, mssd_pkg::SEL_HUNDREDS),
			    frame_of(1'b1, 7'h6F, mssd_pkg::SEL_THOUSANDS)),
			row(16'd10000, 4, frame_of(1'b0, 7'h3F, mssd_pkg::SEL_UNITS),
			    frame_of(1'b0, 7'h3F, mssd_pkg::SEL_TENS),
			    frame_of(1'b0, 7'h3F, mssd_pkg::SEL_HUNDREDS),
			    frame_of(1'b1, mssd_pkg::SEG_BLANK, mssd_pkg::SEL_THOUSANDS)),
			row(16'd65535, 4, frame_of(1'b0, 7'h6D, mssd_pkg::SEL_UNITS),
			    frame_of(1'b0, 7'h4F, mssd_pkg::SEL_TENS),
			    frame_of(1'b0, 7'h6D, mssd_pkg::SEL_HUNDREDS),
			    frame_of(1'b1, mssd_pkg::SEG_BLANK, mssd_pkg::SEL_THOUSANDS)),
			row(16'd10, 0, nil, nil, nil, nil),
			row(16'd99, 0, nil, nil, nil, nil),
			row(16'd100, 0, nil, nil, nil, nil),
			row(16'd999, 0, nil, nil, nil, nil),
			row(16'd1000, 0, nil, nil, nil, nil),
			row(16'd1234, 0, nil, nil, nil, nil),
			row(16'd5678, 0, nil, nil, nil, nil),
			row(16'd9876, 0, nil, nil, nil, nil),
			row(16'd5432, 0, nil, nil, nil, nil),
			row(16'd1010, 0, nil, nil, nil, nil),
			row(16'd9000, 0, nil, nil, nil, nil),
			row(16'd10009, 0, nil, nil, nil, nil),
			row(16'hAAAA, 0, nil, nil, nil, nil),
			row(16'h5555, 0, nil, nil, nil, nil),
			row(16'd1, 0, nil, nil, nil, nil)
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (dir_tab[i]) begin
			offer_value(dir_tab[i].value);
			if (dir_tab[i].n_typed != 0) begin
				for (int k = 0; k < dir_tab[i].n_typed; k++)
					pending_frames.push_back(dir_tab[i].typed[k]);
			end else begin
				queue_digit_frames(dir_tab[i].value);
			end
		end

		// Random values, spread over every shown-digit count and the decade edges
		for (int i = 0; i < RAND_N; i++) begin
			if (i == 30)
				hold_request = 1'b1;
			if (i == 80) begin
				// let everything drain before carrying on
				s_tvalid <= 1'b0;
				do @(posedge clk); while (pending_frames.size() != 0);
			end
			steady = (i >= 90 && i < 130);
			case ($urandom_range(5))
				0: v = VAL_W'($urandom_range(9));
				1: v = VAL_W'($urandom_range(99, 10));
				2: v = VAL_W'($urandom_range(999, 100));
				3: v = VAL_W'($urandom_range(9999, 1000));
				4: v = VAL_W'($urandom_range(65535, 10000));
				default: v = VAL_W'(edges[$urandom_range(3)] - $urandom_range(1));
			endcase
			offer_value(v);
			queue_digit_frames(v);
		end
		steady = 1'b0;

		// Drain, then keep watching for stray frames
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_frames.size() != 0);
		repeat (16) @(posedge clk);

		if (mismatches == 0 && pending_frames.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
